>>> rtl/cic_pkg.sv
// Shared constants, codes and types for the cloud-in-cell mass deposit block.
package cic_pkg;

  localparam int GRID_SIZE = 64;
  localparam int GRID_BITS = $clog2(GRID_SIZE);
  localparam int ADDR_BITS = 3 * GRID_BITS;
  localparam int CELL_W    = 40;
  localparam int G_W       = 32 + GRID_BITS;
  localparam int W_W       = 25;
  localparam int WXY_W     = 26;
  localparam int WC_W      = 27;

  localparam logic [W_W-1:0]    WONE     = W_W'(1) << 24;
  localparam logic [W_W-1:0]    WHALF    = W_W'(1) << 23;
  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  localparam logic       OP_DEPOSIT = 1'b0;
  localparam logic       OP_READ    = 1'b1;
  localparam logic       SCHEME_NGP = 1'b0;

  localparam logic [1:0] REG_SCHEME   = 2'd0;
  localparam logic [1:0] REG_INV_CELL = 2'd1;
  localparam logic [1:0] REG_RSD      = 2'd2;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [CELL_W-1:0]    data;
  } mem_wr_t;

endpackage

>>> rtl/cloud_in_cell_mass_deposit.sv
// Cloud-in-cell deposit: a read passes S_RD and S_DONE and then loads the result register; a deposit
// takes four arithmetic steps, then sends the nearest grid point cell or the cloud-in-cell cells,
// one cell a cycle, through a three-stage read-modify-write loop, and finishes in S_RD and S_DONE.
// One item at a time: the next transfer is taken the cycle after the result register loads,
// later while an earlier result is still stalled.
// After reset a clearing pass zeroes all 262144 cells, one a cycle; only register writes are taken.
module cloud_in_cell_mass_deposit
  import cic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 write_en,
  input  logic [1:0]           reg_index,
  input  logic [31:0]          write_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 operation,
  input  logic [31:0]          pos_x,
  input  logic [31:0]          pos_y,
  input  logic [31:0]          pos_z,
  input  logic signed [31:0]   vel_z,
  input  logic [5:0]           cell_x,
  input  logic [5:0]           cell_y,
  input  logic [5:0]           cell_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CELL_W-1:0]    cell_value,
  output logic                 is_read_result
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_ZS    = 9'b000001000,
    S_GZ    = 9'b000010000,
    S_WGT   = 9'b000100000,
    S_CELL  = 9'b001000000,
    S_RD    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic                     scheme;
  logic [23:0]              inv_cell;
  logic signed [31:0]       rsd_scale;

  logic [31:0]              px, py, pz;
  logic signed [31:0]       vz;
  logic [ADDR_BITS-1:0]     raddr;
  logic                     is_read;
  logic [ADDR_BITS-1:0]     clr_addr;

  logic signed [63:0]       disp_prod;
  logic [G_W-1:0]           gx, gy, gz;
  logic signed [CELL_W-1:0] zs;

  logic [GRID_BITS-1:0]     ix [2];
  logic [GRID_BITS-1:0]     iy [2];
  logic [GRID_BITS-1:0]     iz [2];
  logic [W_W-1:0]           wx [2];
  logic [W_W-1:0]           wy [2];
  logic [W_W-1:0]           wz [2];

  logic [3:0]               k;
  logic [3:0]               k_last;
  logic                     issue;
  logic                     s0_v, s1_v;
  logic [WXY_W-1:0]         s0_wxy;
  logic [W_W-1:0]           s0_wz;
  logic [ADDR_BITS-1:0]     s0_addr, s1_addr;
  logic [WC_W-1:0]          s1_w;

  logic [CELL_W-1:0]        res;
  logic [CELL_W-1:0]        rd_data;
  logic                     rd_en;
  logic [ADDR_BITS-1:0]     rd_addr;
  mem_wr_t                  wr;
  logic [CELL_W:0]          sum;

  logic                     in_xfer;
  logic                     out_free;
  logic                     out_load;

  // Shifted z before saturation, wide enough for pos_z plus the displacement.
  logic signed [48:0]       zsum;
  logic [55:0]              gx_full, gy_full;
  logic [61:0]              gz_full;
  logic [49:0]              wxy_full;
  logic [50:0]              wc_full;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_DONE) && (!is_read || k == 4'd2) && out_free;

  // Register writes are taken in any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scheme    <= 1'b1;
      inv_cell  <= 24'd65536;
      rsd_scale <= '0;
    end else if (write_en) begin
      unique case (reg_index)
        REG_SCHEME:   scheme    <= write_data[0];
        REG_INV_CELL: inv_cell  <= write_data[23:0];
        REG_RSD:      rsd_scale <= write_data;
        default:      ;
      endcase
    end
  end

  assign zsum    = 49'(signed'({1'b0, pz})) + 49'(signed'(disp_prod[63:16]));
  assign gx_full = px * inv_cell;
  assign gy_full = py * inv_cell;
  assign gz_full = zs[G_W-1:0] * inv_cell;
  assign k_last  = (scheme == SCHEME_NGP) ? 4'd0 : 4'd7;
  assign issue   = (state == S_CELL) && (k <= k_last);
  assign wxy_full = wx[k[2]] * wy[k[1]];
  assign wc_full  = s0_wxy * s0_wz;

  // Per-axis cloud-in-cell split; nearest grid point keeps the own cell in slot 0.
  always_ff @(posedge clk) begin
    logic [23:0] f;
    logic [GRID_BITS-1:0] c;
    if (state == S_WGT) begin
      f = gx[31:8]; c = gx[G_W-1:32];
      ix[0] <= (f[23] || scheme == SCHEME_NGP) ? c : c - 1'b1;
      ix[1] <= f[23] ? c + 1'b1 : c;
      wx[0] <= f[23] ? WONE + WHALF - W_W'(f) : WHALF - W_W'(f);
      wx[1] <= f[23] ? W_W'(f) - WHALF : WHALF + W_W'(f);
      f = gy[31:8]; c = gy[G_W-1:32];
      iy[0] <= (f[23] || scheme == SCHEME_NGP) ? c : c - 1'b1;
      iy[1] <= f[23] ? c + 1'b1 : c;
      wy[0] <= f[23] ? WONE + WHALF - W_W'(f) : WHALF - W_W'(f);
      wy[1] <= f[23] ? W_W'(f) - WHALF : WHALF + W_W'(f);
      f = gz[31:8]; c = gz[G_W-1:32];
      iz[0] <= (f[23] || scheme == SCHEME_NGP) ? c : c - 1'b1;
      iz[1] <= f[23] ? c + 1'b1 : c;
      wz[0] <= f[23] ? WONE + WHALF - W_W'(f) : WHALF - W_W'(f);
      wz[1] <= f[23] ? W_W'(f) - WHALF : WHALF + W_W'(f);
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px      <= pos_x;
      py      <= pos_y;
      pz      <= pos_z;
      vz      <= vel_z;
      is_read <= (operation == OP_READ);
      raddr   <= {cell_x[GRID_BITS-1:0], cell_y[GRID_BITS-1:0], cell_z[GRID_BITS-1:0]};
    end
    if (state == S_MUL) begin
      disp_prod <= vz * rsd_scale;
      gx        <= gx_full[G_W-1:0];
      gy        <= gy_full[G_W-1:0];
    end
    if (state == S_ZS) begin
      if (zsum[48:39] == '0 || zsum[48:39] == '1) begin
        zs <= zsum[CELL_W-1:0];
      end else if (zsum[48]) begin
        zs <= {1'b1, {(CELL_W-1){1'b0}}};
      end else begin
        zs <= {1'b0, {(CELL_W-1){1'b1}}};
      end
    end
    if (state == S_GZ) begin
      gz <= gz_full[G_W-1:0];
    end
    s0_wxy  <= wxy_full[49:24];
    s0_wz   <= wz[k[0]];
    s0_addr <= {ix[k[2]], iy[k[1]], iz[k[0]]};
    s1_addr <= s0_addr;
    s1_w    <= (scheme == SCHEME_NGP) ? WC_W'(WONE) : wc_full[50:24];
    if (state == S_RD && !is_read) begin
      res <= '0;
    end else if (state == S_DONE && is_read && k == 4'd1) begin
      res <= rd_data;
    end
  end

  // Memory ports: the clearing pass owns the write port until it ends.
  assign rd_en   = s0_v || (state == S_RD);
  assign rd_addr = (state == S_RD) ? raddr : s0_addr;
  assign sum     = {1'b0, rd_data} + (CELL_W+1)'(s1_w);

  always_comb begin
    wr.en   = (state == S_CLEAR) || s1_v;
    wr.addr = (state == S_CLEAR) ? clr_addr : s1_addr;
    if (state == S_CLEAR) begin
      wr.data = '0;
    end else if (sum[CELL_W]) begin
      wr.data = CELL_MAX;
    end else begin
      wr.data = sum[CELL_W-1:0];
    end
  end

  cic_grid_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control sequencer. In S_DONE, k steps a read through the wait for its data to land.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      k         <= '0;
      s0_v      <= 1'b0;
      s1_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s0_v <= issue;
      s1_v <= s0_v;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          k <= '0;
          if (in_xfer) begin
            state <= (operation == OP_READ) ? S_RD : S_MUL;
          end
        end
        S_MUL:  state <= S_ZS;
        S_ZS:   state <= S_GZ;
        S_GZ:   state <= S_WGT;
        S_WGT:  state <= S_CELL;
        S_CELL: begin
          if (issue) begin
            k <= k + 1'b1;
          end else if (!s0_v) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          k     <= '0;
          state <= S_DONE;
        end
        S_DONE: begin
          if (is_read && k == 4'd0) begin
            k <= 4'd1;
          end else if (is_read && k == 4'd1) begin
            k <= 4'd2;
          end else if (out_free) begin
            cell_value     <= res;
            is_read_result <= is_read;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/cic_grid_mem.sv
// Density grid store: one write port and one registered read port.
module cic_grid_mem
  import cic_pkg::*;
(
  input  logic                 clk,
  input  mem_wr_t              wr,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [CELL_W-1:0]    rd_data
);

  logic [CELL_W-1:0] mem [GRID_SIZE*GRID_SIZE*GRID_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sim/tb.sv
// Testbench for the cloud-in-cell mass deposit block: a self-checking predictor and random stimulus.
`timescale 1ns / 100ps

module tb
  import cic_pkg::*;
();

  typedef struct {
    logic              op;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
    logic signed [31:0] vz;
    logic [5:0]        cx;
    logic [5:0]        cy;
    logic [5:0]        cz;
  } particle_item_t;

  typedef struct {
    logic [CELL_W-1:0] value;
    logic              is_read;
  } cell_result_t;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint ZSAT_HI = 64'sd549755813887;
  localparam longint ZSAT_LO = -64'sd549755813888;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [1:0] reg_index = '0;
  logic [31:0] write_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_z = '0;
  logic [5:0] cell_x = '0, cell_y = '0, cell_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CELL_W-1:0] cell_value;
  logic is_read_result;

  cloud_in_cell_mass_deposit dut (.*);

  // Predictor state: a sparse copy of the grid and the three registers.
  logic [CELL_W-1:0] grid_mass [logic [ADDR_BITS-1:0]];
  logic   pred_scheme = 1'b1;
  longint pred_inv = 65536;
  longint pred_rsd = 0;

  particle_item_t pending_items[$];
  cell_result_t   expected_cells[$];
  int sender_idle_pct = 16;
  int receiver_idle_pct = 46;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int fail_count = 0;
  longint cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [CELL_W-1:0] mass_at(logic [5:0] x, logic [5:0] y, logic [5:0] z);
    if (grid_mass.exists({x, y, z})) return grid_mass[{x, y, z}];
    return '0;
  endfunction

  function automatic void add_mass(logic [5:0] x, logic [5:0] y, logic [5:0] z, longint w);
    logic [CELL_W:0] sum;
    sum = {1'b0, mass_at(x, y, z)} + (CELL_W+1)'(w);
    grid_mass[{x, y, z}] = sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
  endfunction

  // Triangle kernel weights along one axis of the grid coordinate g (Q.32).
  function automatic void axis_weights(input longint g, output logic [5:0] i0,
                                       output logic [5:0] i1, output longint w0,
                                       output longint w1);
    logic [5:0]  c;
    logic [23:0] f;
    c = g[37:32];
    f = g[31:8];
    if (f < 24'h800000) begin
      i0 = c - 6'd1;
      i1 = c;
      w0 = 64'h800000 - f;
      w1 = 64'h800000 + f;
    end else begin
      i0 = c;
      i1 = c + 6'd1;
      w0 = 64'h1800000 - f;
      w1 = f - 64'h800000;
    end
  endfunction

  function automatic cell_result_t deposit_or_read(particle_item_t it);
    cell_result_t r;
    longint gx, gy, gz, zs, wxy;
    logic [5:0] ix[2], iy[2], iz[2];
    longint wx[2], wy[2], wz[2];
    r.value = '0;
    r.is_read = it.op;
    if (it.op == OP_READ) begin
      r.value = mass_at(it.cx, it.cy, it.cz);
      return r;
    end
    zs = longint'({32'b0, it.pz}) + ((longint'(it.vz) * pred_rsd) >>> 16);
    if (zs > ZSAT_HI) zs = ZSAT_HI;
    if (zs < ZSAT_LO) zs = ZSAT_LO;
    gx = longint'({32'b0, it.px}) * pred_inv;
    gy = longint'({32'b0, it.py}) * pred_inv;
    gz = zs * pred_inv;
    if (pred_scheme == SCHEME_NGP) begin
      add_mass(gx[37:32], gy[37:32], gz[37:32], 64'h1000000);
      return r;
    end
    axis_weights(gx, ix[0], ix[1], wx[0], wx[1]);
    axis_weights(gy, iy[0], iy[1], wy[0], wy[1]);
    axis_weights(gz, iz[0], iz[1], wz[0], wz[1]);
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++) begin
        wxy = (wx[a] * wy[b]) >> 24;
        for (int c = 0; c < 2; c++)
          add_mass(ix[a], iy[b], iz[c], (wxy * wz[c]) >> 24);
      end
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sender: one transfer per accepted item; the predictor runs at acceptance.
  always @(posedge clk) begin
    particle_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        it.op = operation; it.px = pos_x; it.py = pos_y; it.pz = pos_z; it.vz = vel_z;
        it.cx = cell_x; it.cy = cell_y; it.cz = cell_z;
        expected_cells = {expected_cells, deposit_or_read(it)};
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          it = pending_items.pop_front();
          operation <= it.op; pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
          vel_z <= it.vz; cell_x <= it.cx; cell_y <= it.cy; cell_z <= it.cz;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off on request from the test so the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    cell_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result: cell_value %0h is_read_result %0b", cell_value,
               is_read_result);
        fail_count++;
      end else begin
        e = expected_cells.pop_front();
        if (cell_value !== e.value) begin
          $error("cell_value expected %0h actual %0h", e.value, cell_value);
          fail_count++;
        end
        if (is_read_result !== e.is_read) begin
          $error("is_read_result expected %0b actual %0b", e.is_read, is_read_result);
          fail_count++;
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    write_en <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    case (idx)
      REG_SCHEME:   pred_scheme = data[0];
      REG_INV_CELL: pred_inv = longint'(data[23:0]);
      REG_RSD:      pred_rsd = longint'($signed(data));
      default: ;
    endcase
  endtask

  task automatic set_registers(logic scheme, logic [31:0] inv, logic [31:0] rsd);
    reg_write(REG_SCHEME, {31'b0, scheme});
    reg_write(REG_INV_CELL, inv);
    reg_write(REG_RSD, rsd);
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  // Sampled at the falling edge, when the sender's and monitor's updates have settled.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_cells.size() != 0)
      @(negedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic queue_deposit(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] v);
    particle_item_t it;
    it.op = OP_DEPOSIT; it.px = x; it.py = y; it.pz = z; it.vz = v;
    it.cx = 6'($urandom); it.cy = 6'($urandom); it.cz = 6'($urandom);
    pending_items = {pending_items, it};
  endtask

  task automatic queue_read(logic [5:0] x, logic [5:0] y, logic [5:0] z);
    particle_item_t it;
    it.op = OP_READ; it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.vz = $urandom; it.cx = x; it.cy = y; it.cz = z;
    pending_items = {pending_items, it};
  endtask

  // Mostly particles near the origin, so that reads land on cells holding mass.
  task automatic queue_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 80)
          queue_deposit($urandom_range(32'h7FFFF), $urandom_range(32'h7FFFF),
                        $urandom_range(32'h7FFFF), $urandom_range(32'h3FFFF) - 32'h20000);
        else
          queue_deposit($urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(99) < 80) begin
        queue_read(6'($urandom_range(9) - 1), 6'($urandom_range(9) - 1),
                   6'($urandom_range(9) - 1));
      end else begin
        queue_read(6'($urandom), 6'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset; an unknown register index must be ignored.
    reg_write(2'd3, 32'hFFFFFFFF);
    set_registers(1'b1, 32'd65536, 32'd0);
    queue_deposit(32'd0, 32'd0, 32'd0, 32'd0);
    queue_deposit(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
    queue_deposit(32'h00038000, 32'h00014000, 32'h0002C000, 32'd0);
    queue_read(6'd0, 6'd0, 6'd0);
    queue_read(6'd63, 6'd63, 6'd63);
    queue_read(6'd63, 6'd0, 6'd63);
    queue_read(6'd3, 6'd1, 6'd2);
    wait_drained();

    // Nearest grid point with zero cell size reciprocal and the largest shift.
    set_registers(1'b0, 32'd0, 32'h7FFFFFFF);
    queue_deposit(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'h7FFFFFFF);
    queue_read(6'd0, 6'd0, 6'd0);
    wait_drained();

    // Cloud in cell with zero reciprocal splits every axis across the wrap.
    set_registers(1'b1, 32'd0, 32'd0);
    queue_deposit(32'h00050000, 32'h00060000, 32'h00070000, 32'h80000000);
    queue_read(6'd63, 6'd63, 6'd63);
    queue_read(6'd0, 6'd63, 6'd0);
    wait_drained();

    // Largest reciprocal and most negative shift: z saturates both ways.
    set_registers(1'b1, 32'h00FFFFFF, 32'h80000000);
    queue_deposit(32'h00010000, 32'h00020000, 32'h00030000, 32'h7FFFFFFF);
    queue_deposit(32'h00010000, 32'h00020000, 32'hFFFFFFFF, 32'h80000000);
    queue_deposit(32'h00000100, 32'h0, 32'h00008000, 32'hFFFFFFFF);
    queue_read(6'd0, 6'd0, 6'd0);
    queue_read(6'd1, 6'd2, 6'd63);
    wait_drained();

    set_registers(1'b1, 32'd65536, 32'h00008000);
    queue_random(300);
    wait_drained();

    sender_idle_pct = 46;
    receiver_idle_pct = 16;
    set_registers(1'b0, 32'h00020000, 32'hFFFF0000);
    hold_requests++;
    queue_random(300);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_registers(1'b1, $urandom_range(32'h30000), $urandom);
    queue_random(300);
    wait_drained();

    if (fail_count == 0 && expected_cells.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
